@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/rdp_pkg.sv @@
// Shared constants and types of the planar RLE plane decoder.
`default_nettype none
package rdp_pkg;
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CFG_W       = 13;
  localparam int CFG_AW      = 1;
  localparam int LOG_W       = $clog2(MAX_WIDTH);
  localparam int COL_W       = (LOG_W > 12) ? LOG_W : 12;
  localparam int RAM_AW      = (LOG_W > 0) ? LOG_W : 1;
  localparam int LINE_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int OUT_COL_W   = 12;
  localparam int OUT_ROW_W   = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd64;

  localparam logic [7:0] RUN_CODE_MIN = 8'd16;
  localparam logic [7:0] RUN_CODE_MAX = 8'd47;

  // One stream byte with both of its possible meanings worked out.
  typedef struct packed {
    logic [7:0] raw;    // plain pixel value (first line)
    logic [7:0] delta;  // unfolded signed delta (later lines)
    logic [3:0] lit;    // literal count if control byte
    logic [5:0] run;    // run length if control byte
  } byte_cls_t;

  typedef struct packed {
    logic      valid;
    byte_cls_t cls;
  } queue_out_t;

  typedef enum logic [1:0] {
    ST_TAKE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;
endpackage
`default_nettype wire

@@ rtl/rdp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module rdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output      logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/rdp_front.sv @@
// Input side: takes stream bytes and classifies them for the queue.
`default_nettype none
module rdp_front (
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] stream_byte
  input  wire logic               q_full,
  output      logic               push,
  output      rdp_pkg::byte_cls_t push_data
);
  import rdp_pkg::*;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t  c;
    logic [7:0] code;
    code    = {b[3:0], b[7:4]};
    c.raw   = b;
    // odd means negative: -(x+1) is ~x
    c.delta = b[0] ? ~{1'b0, b[7:1]} : {1'b0, b[7:1]};
    if (code >= RUN_CODE_MIN && code <= RUN_CODE_MAX) begin
      c.run = code[5:0];
      c.lit = 4'd0;
    end else begin
      c.run = {2'b00, b[3:0]};
      c.lit = b[7:4];
    end
    return c;
  endfunction

  assign s_tready  = !q_full;
  assign push      = s_tvalid && !q_full;
  assign push_data = classify(s_tdata);
endmodule
`default_nettype wire

@@ rtl/rdp_queue.sv @@
// Short queue between the classifier and the pixel engine.
`default_nettype none
module rdp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire rdp_pkg::byte_cls_t   push_data,
  output      logic                 full,
  input  wire logic                 pop,
  output      rdp_pkg::queue_out_t  head
);
  import rdp_pkg::*;

  byte_cls_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cls   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/rdp_back.sv @@
// Pixel engine: applies control/literal bytes, expands runs, keeps the line above.
`default_nettype none
module rdp_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rdp_pkg::queue_out_t        head,
  output      logic                       pop,
  input  wire logic [rdp_pkg::CFG_W-1:0]  image_width,
  input  wire logic [rdp_pkg::CFG_W-1:0]  image_height,
  output      logic                       m_tvalid,
  input  wire logic                       m_tready,
  output      logic [31:0]                m_tdata,  // [7:0] pixel_value, [19:8] pixel_column,
                                                    // [31:20] pixel_row
  output      logic                       m_tuser,  // [0] run_last
  output      logic                       m_tlast   // image_done
);
  import rdp_pkg::*;

  back_state_t       state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [LINE_W-1:0] line, line_next;
  logic [3:0]        lits, lits_next;
  logic [5:0]        run, run_next;
  logic [7:0]        last, last_next;
  logic              finished, finished_next;

  logic [COL_W:0]    eff_w;
  logic [LINE_W-1:0] eff_h;
  logic [COL_W:0]    col_inc;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] row_full;
  logic              emit_eol;
  logic              last_line;
  logic              out_free;
  logic              emit;
  logic              do_end;
  logic              line_end;
  logic [7:0]        emit_v;
  logic [7:0]        above;
  logic [7:0]        pix;
  logic [7:0]        ram_rdata;
  logic              fwd_hit;
  logic [7:0]        fwd_data;
  logic [RAM_AW-1:0] waddr;
  logic [RAM_AW-1:0] raddr;

  always_comb begin
    if (image_width == '0) begin
      eff_w = (COL_W+1)'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W+1)'(image_width);
    end
    if (image_height == '0) begin
      eff_h = LINE_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = LINE_W'(MAX_HEIGHT);
    end else begin
      eff_h = LINE_W'(image_height);
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign col_inc   = {1'b0, col} + (COL_W+1)'(1);
  assign emit_eol  = (col_inc >= eff_w);
  assign line_inc  = line + LINE_W'(1);
  assign last_line = (line_inc >= eff_h);
  assign row_full  = eff_h - LINE_W'(1) - line;
  assign above     = fwd_hit ? fwd_data : ram_rdata;
  assign pix       = (line == '0) ? emit_v : 8'(emit_v + above);
  assign line_end  = do_end || (emit && emit_eol);

  always_comb begin
    state_next    = state;
    col_next      = col;
    line_next     = line;
    lits_next     = lits;
    run_next      = run;
    last_next     = last;
    finished_next = finished;
    pop           = 1'b0;
    emit          = 1'b0;
    do_end        = 1'b0;
    emit_v        = last;
    unique case (state)
      ST_TAKE: begin
        if (head.valid) begin
          if (finished) begin
            pop = 1'b1;
          end else if (line >= eff_h) begin
            finished_next = 1'b1;
            pop           = 1'b1;
          end else if ({1'b0, col} >= eff_w) begin
            // width shrank under the current column: close the line first
            do_end = 1'b1;
          end else if (lits != '0) begin
            if (out_free) begin
              pop       = 1'b1;
              emit      = 1'b1;
              emit_v    = (line == '0) ? head.cls.raw : head.cls.delta;
              lits_next = lits - 4'd1;
              last_next = emit_v;
              if (lits == 4'd1 && run != '0 && !emit_eol) begin
                state_next = ST_RUN;
              end
            end
          end else begin
            pop       = 1'b1;
            lits_next = head.cls.lit;
            run_next  = head.cls.run;
            if (head.cls.lit == '0 && head.cls.run != '0) begin
              state_next = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_v   = last;
          run_next = run - 6'd1;
          if (run == 6'd1 || emit_eol) begin
            state_next = ST_TAKE;
          end
        end
      end
      default: begin
        state_next = ST_TAKE;
      end
    endcase
    if (emit) begin
      col_next = col_inc[COL_W-1:0];
    end
    if (line_end) begin
      col_next      = '0;
      line_next     = line_inc;
      lits_next     = '0;
      run_next      = '0;
      last_next     = '0;
      finished_next = last_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_TAKE;
      col      <= '0;
      line     <= '0;
      lits     <= '0;
      run      <= '0;
      last     <= '0;
      finished <= 1'b0;
      m_tvalid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      line     <= line_next;
      lits     <= lits_next;
      run      <= run_next;
      last     <= last_next;
      finished <= finished_next;
      fwd_hit  <= emit && (waddr == raddr);
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= pix;
    if (emit) begin
      m_tdata <= {row_full[OUT_ROW_W-1:0], col[OUT_COL_W-1:0], pix};
      m_tuser <= (state_next == ST_TAKE);
      m_tlast <= emit_eol && last_line;
    end
  end

  // read address tracks the next column so the pixel above is ready in time
  assign waddr = col[RAM_AW-1:0];
  assign raddr = col_next[RAM_AW-1:0];

  rdp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (emit),
    .waddr (waddr),
    .wdata (pix),
    .raddr (raddr),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

@@ rtl/planar_rle_delta_plane_decoder.sv @@
// A literal byte's pixel is registered at the output as the byte is popped.
// Throughput: one pixel per cycle unless the queue runs dry or the output
// stalls; a control byte emits none; one line-store port pair sets the pace.
// Reset (rst, synchronous, high) clears counters, queue and output; the line
// store is not cleared and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module planar_rle_delta_plane_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] stream_byte
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [31:0]                 m_tdata,  // [7:0] pixel_value, [19:8] pixel_column,
                                                     // [31:20] pixel_row
  output      logic                        m_tuser,  // [0] run_last
  output      logic                        m_tlast,  // image_done
  input  wire logic                        cfg_we,
  input  wire logic [rdp_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [rdp_pkg::CFG_W-1:0]   cfg_data
);
  import rdp_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             q_full;
  logic             push;
  byte_cls_t        push_data;
  logic             pop;
  queue_out_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  rdp_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  rdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .image_width  (image_width),
    .image_height (image_height),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  // the final pixel of the plane closes its byte and lands on row zero
  `ASSERT_IMPL(a_done_is_byte_last, clk, rst, m_tvalid && m_tlast, m_tuser)
  `ASSERT_IMPL(a_done_on_row_zero, clk, rst, m_tvalid && m_tlast, m_tdata[31:20] == '0)
  // nothing follows the plane until reset
  `ASSERT_NEXT(a_quiet_after_done, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid)
endmodule
`default_nettype wire
